// ===== rtl/core/vsrc_pkg.sv =====
// Shared types, constants and a helper function for the variable-step RC low-pass filter.
`default_nettype none
package vsrc_pkg;

    localparam int BETA_BITS = 16;
    localparam int QUOT_BITS = 21;
    localparam int DT_SHIFT  = QUOT_BITS - 16;
    localparam int HORNER_K  = 9;

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;

    localparam logic [1:0] REG_TAU     = 2'd0;
    localparam logic [1:0] REG_INITIAL = 2'd1;
    localparam logic [1:0] REG_START   = 2'd2;

    typedef struct packed {
        logic signed [31:0] sample;
        logic [31:0]        dt;
    } vsrc_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOG,
        ST_FRAC,
        ST_HINIT,
        ST_HMUL,
        ST_HREC,
        ST_HCOR,
        ST_SHIFT,
        ST_MIX,
        ST_FIN
    } vsrc_state_t;

    function automatic logic [31:0] vsrc_recip(input logic [3:0] k);
        logic [31:0] r;
        unique case (k)
            4'd1:    r = 32'd4294967295;
            4'd2:    r = 32'd2147483647;
            4'd3:    r = 32'd1431655765;
            4'd4:    r = 32'd1073741823;
            4'd5:    r = 32'd858993459;
            4'd6:    r = 32'd715827882;
            4'd7:    r = 32'd613566756;
            4'd8:    r = 32'd536870911;
            4'd9:    r = 32'd477218588;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/vsrc_front.sv =====
// Front end: accepts sample beats and forms the elapsed time since the previous one or since the loaded start time.
`default_nettype none
module vsrc_front
    import vsrc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] sample,
    input  wire logic [31:0]        timestamp_us,
    input  wire logic               load_time,
    input  wire logic [31:0]        load_value,
    input  wire logic               q_full,
    output logic                    q_push,
    output vsrc_item_t              q_item
);

    logic [31:0] last_time_reg;
    logic [31:0] last_time_next;

    always_comb
    begin
        in_stall       = q_full;
        q_push         = in_valid && !q_full;
        q_item.sample  = sample;
        q_item.dt      = timestamp_us - last_time_reg;
        last_time_next = last_time_reg;
        if (load_time)
        begin
            last_time_next = load_value;
        end
        else if (q_push)
        begin
            last_time_next = timestamp_us;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
        end
        else
        begin
            last_time_reg <= last_time_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/vsrc_queue.sv =====
// Two-entry queue between the front end and the arithmetic back end.
`default_nettype none
module vsrc_queue
    import vsrc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire vsrc_item_t push_item,
    output logic      full,
    output logic      not_empty,
    input  wire logic pop,
    output vsrc_item_t pop_item
);

    vsrc_item_t  slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    always_comb
    begin
        full        = (count_reg == 2'd2);
        not_empty   = (count_reg != 2'd0);
        pop_item    = slot_reg[rd_ptr_reg];
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/vsrc_back.sv =====
// Back end: divider, exponential approximation, output mix and output register.
`default_nettype none
module vsrc_back
    import vsrc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [31:0]        tau,
    input  wire logic               load_held,
    input  wire logic [31:0]        load_value,
    input  wire logic               q_not_empty,
    output logic                    q_pop,
    input  wire vsrc_item_t         q_item,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      filtered
);

    vsrc_state_t        state_reg, state_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [32:0]        rem_reg, rem_next;
    logic [QUOT_BITS-1:0] div_lo_reg, div_lo_next;
    logic [QUOT_BITS-1:0] quot_reg, quot_next;
    logic [60:0]        prod_reg, prod_next;
    logic [62:0]        rprod_reg, rprod_next;
    logic [30:0]        p_reg, p_next;
    logic [29:0]        u_reg, u_next;
    logic [30:0]        t_reg, t_next;
    logic [5:0]         n_reg, n_next;
    logic [3:0]         k_reg, k_next;
    logic [BETA_BITS:0] beta_reg, beta_next;
    logic signed [31:0] sample_reg, sample_next;
    logic signed [49:0] m1_reg, m1_next, m2_reg, m2_next;
    logic [31:0]        held_reg, held_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_reg, out_next;

    logic [32:0]        rem_shift;
    logic [21:0]        y;
    logic [30:0]        q0;
    logic [34:0]        q0k;
    logic [30:0]        rmd;
    logic [30:0]        q;
    logic [30:0]        t_shifted;
    logic [30:0]        beta_sum;
    logic signed [50:0] acc;
    logic signed [34:0] rounded;
    logic               slot_free;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        div_lo_next    = div_lo_reg;
        quot_next      = quot_reg;
        prod_next      = prod_reg;
        rprod_next     = rprod_reg;
        p_next         = p_reg;
        u_next         = u_reg;
        t_next         = t_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        beta_next      = beta_reg;
        sample_next    = sample_reg;
        m1_next        = m1_reg;
        m2_next        = m2_reg;
        held_next      = held_reg;
        out_next       = out_reg;
        q_pop          = 1'b0;
        slot_free      = !out_valid_reg || !out_stall;
        out_valid_next = out_valid_reg && out_stall;

        rem_shift = {rem_reg[31:0], div_lo_reg[QUOT_BITS-1]};
        y         = prod_reg[51:30];
        q0        = rprod_reg[62:32];
        q0k       = {4'b0, q0} * {31'b0, k_reg};
        rmd       = p_reg - q0k[30:0];
        q         = q0 + {30'b0, (rmd >= {27'b0, k_reg})};
        t_shifted = t_reg >> n_reg;
        beta_sum  = t_shifted + (31'd1 << (29 - BETA_BITS));
        acc       = 51'(m1_reg) + 51'(m2_reg);
        rounded   = 35'((acc + (51'sd1 <<< (BETA_BITS - 1))) >>> BETA_BITS);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop       = 1'b1;
                    sample_next = q_item.sample;
                    rem_next    = {6'b0, q_item.dt[31:DT_SHIFT]};
                    div_lo_next = {q_item.dt[DT_SHIFT-1:0], 16'b0};
                    quot_next   = '0;
                    cnt_next    = 5'(QUOT_BITS);
                    if ({5'b0, q_item.dt} >= {tau, 5'b0})
                    begin
                        beta_next  = '0;
                        state_next = ST_MIX;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (rem_shift >= {1'b0, tau})
                begin
                    rem_next  = rem_shift - {1'b0, tau};
                    quot_next = {quot_reg[QUOT_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_shift;
                    quot_next = {quot_reg[QUOT_BITS-2:0], 1'b0};
                end
                div_lo_next = {div_lo_reg[QUOT_BITS-2:0], 1'b0};
                cnt_next    = cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    state_next = ST_LOG;
                end
            end
            ST_LOG:
            begin
                prod_next  = 61'({31'b0, quot_reg} * {21'b0, LOG2E_Q30});
                state_next = ST_FRAC;
            end
            ST_FRAC:
            begin
                n_next     = y[21:16];
                prod_next  = 61'({30'b0, y[15:0]} * {16'b0, LN2_Q30});
                state_next = ST_HINIT;
            end
            ST_HINIT:
            begin
                u_next     = prod_reg[45:16];
                t_next     = ONE_Q30;
                k_next     = 4'(HORNER_K);
                state_next = ST_HMUL;
            end
            ST_HMUL:
            begin
                prod_next  = {1'b0, u_reg} * {30'b0, t_reg};
                state_next = ST_HREC;
            end
            ST_HREC:
            begin
                p_next     = prod_reg[60:30];
                rprod_next = {32'b0, prod_reg[60:30]} * {31'b0, vsrc_recip(k_reg)};
                state_next = ST_HCOR;
            end
            ST_HCOR:
            begin
                t_next = ONE_Q30 - q;
                k_next = k_reg - 4'd1;
                if (k_reg == 4'd1)
                begin
                    state_next = ST_SHIFT;
                end
                else
                begin
                    state_next = ST_HMUL;
                end
            end
            ST_SHIFT:
            begin
                beta_next  = beta_sum[30:30-BETA_BITS];
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                m1_next    = 50'($signed({1'b0, beta_reg}) * $signed(held_reg));
                m2_next    = 50'($signed({1'b0, (18'd1 << BETA_BITS) - {1'b0, beta_reg}})
                                 * sample_reg);
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (slot_free)
                begin
                    if (rounded > 35'sd2147483647)
                    begin
                        out_next = 32'sh7FFF_FFFF;
                    end
                    else if (rounded < -35'sd2147483648)
                    begin
                        out_next = 32'sh8000_0000;
                    end
                    else
                    begin
                        out_next = rounded[31:0];
                    end
                    held_next      = out_next;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_held)
        begin
            held_next = load_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            held_reg      <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        rem_reg    <= rem_next;
        div_lo_reg <= div_lo_next;
        quot_reg   <= quot_next;
        prod_reg   <= prod_next;
        rprod_reg  <= rprod_next;
        p_reg      <= p_next;
        u_reg      <= u_next;
        t_reg      <= t_next;
        n_reg      <= n_next;
        k_reg      <= k_next;
        beta_reg   <= beta_next;
        sample_reg <= sample_next;
        m1_reg     <= m1_next;
        m2_reg     <= m2_next;
        out_reg    <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign filtered  = out_reg;

endmodule
`default_nettype wire

// ===== rtl/core/variable_step_rc_lowpass.sv =====
// Top level of the variable-step RC low-pass filter with its register port.
// Each sample beat passes through the back end in this order: taking the item from the
// queue, the bit-serial division of the elapsed time by tau, the base-2 split, the nine
// Horner steps of the exponential (a multiply, a reciprocal multiply and a correction
// each), and then the shift, the mix and the rounding, which waits for a free output slot.
// Long gaps (elapsed time at least 32 tau) skip the exponential and go straight to the mix.
// Up to two beats wait in a queue, and a finished result waits in its own register.
`default_nettype none
module variable_step_rc_lowpass
    import vsrc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] sample,
    input  wire logic [31:0]        timestamp_us,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      filtered,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [31:0] tau_reg, tau_next;
    logic [31:0] initial_reg, initial_next;
    logic [31:0] start_reg, start_next;
    logic        wr_en;
    logic        load_held;
    logic        load_time;
    logic        q_full;
    logic        q_push;
    logic        q_pop;
    logic        q_not_empty;
    vsrc_item_t  push_item;
    vsrc_item_t  pop_item;

    always_comb
    begin
        pready       = 1'b1;
        wr_en        = psel && penable && pwrite;
        load_held    = wr_en && (paddr[3:2] == REG_INITIAL);
        load_time    = wr_en && (paddr[3:2] == REG_START);
        tau_next     = (wr_en && (paddr[3:2] == REG_TAU)) ? pwdata : tau_reg;
        initial_next = load_held ? pwdata : initial_reg;
        start_next   = load_time ? pwdata : start_reg;
        unique case (paddr[3:2])
            REG_TAU:     prdata = tau_reg;
            REG_INITIAL: prdata = initial_reg;
            REG_START:   prdata = start_reg;
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tau_reg     <= 32'd1000;
            initial_reg <= '0;
            start_reg   <= '0;
        end
        else
        begin
            tau_reg     <= tau_next;
            initial_reg <= initial_next;
            start_reg   <= start_next;
        end
    end

    vsrc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .timestamp_us (timestamp_us),
        .load_time    (load_time),
        .load_value   (pwdata),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    vsrc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .pop_item  (pop_item)
    );

    vsrc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .tau         (tau_reg),
        .load_held   (load_held),
        .load_value  (pwdata),
        .q_not_empty (q_not_empty),
        .q_pop       (q_pop),
        .q_item      (pop_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .filtered    (filtered)
    );

endmodule
`default_nettype wire

// ===== test/tb_variable_step_rc_lowpass.sv =====
// Self-checking testbench for the variable-step RC low-pass filter.
`timescale 1ns / 1ps
module tb_variable_step_rc_lowpass;
    import vsrc_pkg::*;

    class filter_scoreboard;
        bit [31:0] tau;
        bit [31:0] last_ts;
        bit signed [31:0] held;
        bit signed [31:0] pending[$];
        int mismatches;

        function new();
            tau = 32'd1000;
            last_ts = 32'd0;
            held = 32'sd0;
            mismatches = 0;
        endfunction

        function bit [16:0] decay(bit [31:0] dt);
            bit [63:0] x;
            bit [63:0] y;
            bit [63:0] u;
            bit [63:0] t;
            bit [63:0] b;
            bit [31:0] n;
            if (tau == 0)
                return 0;
            x = {dt, 16'd0} / {32'd0, tau};
            if (x >= (64'd32 << 16))
                return 0;
            y = (x * 64'd1549082005) >> 30;
            n = y[47:16];
            u = ({48'd0, y[15:0]} * 64'd744261118) >> 16;
            t = 64'd1 << 30;
            for (int k = 9; k >= 1; k--)
                t = (64'd1 << 30) - (((u * t) >> 30) / k);
            b = (n >= 63) ? 64'd0 : (t >> n);
            b = (b + (64'd1 << 13)) >> 14;
            return b[16:0];
        endfunction

        function void note_sample(bit signed [31:0] s, bit [31:0] ts);
            longint beta;
            longint acc;
            longint r;
            beta = decay(ts - last_ts);
            acc = beta * longint'(held) + (65536 - beta) * longint'(s);
            r = (acc + 32768) >>> 16;
            if (r > 64'sd2147483647)
                r = 64'sd2147483647;
            if (r < -64'sd2147483648)
                r = -64'sd2147483648;
            held = r[31:0];
            last_ts = ts;
            pending.push_back(held);
        endfunction

        function void check_output(bit signed [31:0] got);
            bit signed [31:0] want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output beat: filtered=%0d", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("filtered mismatch: expected %0d, actual %0d", want, got);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] sample = '0;
    logic [31:0] timestamp_us = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] filtered;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    filter_scoreboard board = new();
    int send_idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    bit [31:0] now_us = 0;

    variable_step_rc_lowpass i_dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                board.note_sample(sample, timestamp_us);
            if (out_valid && !out_stall)
                board.check_output(filtered);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 20000)
            begin
                $display("variable_step_rc_lowpass test failed");
                $finish;
            end
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_TAU)
            board.tau = value;
        else if (idx == REG_INITIAL)
            board.held = value;
        else if (idx == REG_START)
            board.last_ts = value;
    endtask

    task automatic send_sample(logic signed [31:0] s, logic [31:0] ts);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sample <= s;
        timestamp_us <= ts;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_sample();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_gap(logic [31:0] t);
        case ($urandom_range(7))
            0: return 0;
            1: return $urandom;
            2: return t * $urandom_range(30, 40);
            3: return $urandom_range(1, 3);
            default: return $urandom_range(0, (t > 32'd100000 || t == 0) ? 32'd100000 : t * 4);
        endcase
    endfunction

    task automatic random_phase(int count, int idle, int stall);
        logic [31:0] t;
        send_idle_pct = idle;
        stall_pct = stall;
        for (int i = 0; i < count; i++)
        begin
            t = board.tau;
            now_us = now_us + rand_gap(t);
            send_sample(rand_sample(), now_us);
        end
        drain();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        send_sample(32'sh00010000, 32'd0);
        send_sample(32'sh00010000, 32'd500);
        send_sample(32'sh7fffffff, 32'd1500);
        send_sample(32'sh80000000, 32'd1501);
        send_sample(32'sh7fffffff, 32'd40000);
        send_sample(32'sh80000000, 32'd10);
        send_sample(32'sh12345678, 32'hffffffff);
        send_sample(-32'sh00000001, 32'd999);
        drain();
        write_reg(REG_TAU, 32'd0);
        write_reg(REG_INITIAL, 32'sh7fffffff);
        write_reg(REG_START, 32'hfffffff0);
        send_sample(32'sh00020000, 32'h00000010);
        send_sample(32'sh80000000, 32'h00000010);
        drain();
        write_reg(REG_TAU, 32'hffffffff);
        write_reg(REG_INITIAL, 32'sh80000000);
        write_reg(REG_START, 32'd0);
        send_sample(32'sh7fffffff, 32'hffffffff);
        send_sample(32'sh7fffffff, 32'h7fffffff);
        send_sample(32'sh00000000, 32'h7fffffff);
        drain();
        write_reg(REG_TAU, 32'd1);
        write_reg(REG_INITIAL, 32'sh00001234);
        write_reg(REG_START, 32'd100);
        send_sample(32'sh7fffffff, 32'd100);
        send_sample(32'sh55555555, 32'd101);
        send_sample(32'shaaaaaaaa, 32'd140);
        drain();

        write_reg(REG_TAU, 32'd1000);
        now_us = 32'd0;
        write_reg(REG_START, now_us);
        random_phase(200, 0, 0);
        write_reg(REG_TAU, $urandom_range(1, 50));
        random_phase(200, 46, 0);
        write_reg(REG_TAU, $urandom);
        write_reg(REG_INITIAL, $urandom);
        random_phase(200, 0, 46);
        write_reg(REG_TAU, $urandom_range(100, 100000));
        now_us = $urandom;
        write_reg(REG_START, now_us);
        random_phase(200, 35, 35);

        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("variable_step_rc_lowpass test passed");
        else
            $display("variable_step_rc_lowpass test failed");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/vsrc_pkg.sv
rtl/core/vsrc_front.sv
rtl/core/vsrc_queue.sv
rtl/core/vsrc_back.sv
rtl/core/variable_step_rc_lowpass.sv
test/tb_variable_step_rc_lowpass.sv
